// ----- rtl/chip8_instruction_decoder_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the CHIP-8 instruction decoder
// Concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define CHIP8_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, ignored during reset.
`define C8DEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge, ignored during reset.
`define C8DEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/c8dec_pkg.sv -----
// ---------------------------------------------------------------------------
// CHIP-8 decoder package
// Operation codes, flow classes, bus widths and the decode result type.
// ---------------------------------------------------------------------------
package c8dec_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    // Dense operation codes.
    localparam logic [5:0] OP_CLS     = 6'd0;
    localparam logic [5:0] OP_RTS     = 6'd1;
    localparam logic [5:0] OP_SCRIGHT = 6'd2;
    localparam logic [5:0] OP_SCLEFT  = 6'd3;
    localparam logic [5:0] OP_LOW     = 6'd4;
    localparam logic [5:0] OP_HIGH    = 6'd5;
    localparam logic [5:0] OP_SCDOWN  = 6'd6;
    localparam logic [5:0] OP_SYS     = 6'd7;
    localparam logic [5:0] OP_JMP     = 6'd8;
    localparam logic [5:0] OP_CALL    = 6'd9;
    localparam logic [5:0] OP_SKE_K   = 6'd10;
    localparam logic [5:0] OP_SKNE_K  = 6'd11;
    localparam logic [5:0] OP_SKE_R   = 6'd12;
    localparam logic [5:0] OP_MOV_K   = 6'd13;
    localparam logic [5:0] OP_ADD_K   = 6'd14;
    localparam logic [5:0] OP_MOV_R   = 6'd15;
    localparam logic [5:0] OP_OR      = 6'd16;
    localparam logic [5:0] OP_AND     = 6'd17;
    localparam logic [5:0] OP_XOR     = 6'd18;
    localparam logic [5:0] OP_ADD_R   = 6'd19;
    localparam logic [5:0] OP_SUB     = 6'd20;
    localparam logic [5:0] OP_SHR     = 6'd21;
    localparam logic [5:0] OP_SUBN    = 6'd22;
    localparam logic [5:0] OP_SHL     = 6'd23;
    localparam logic [5:0] OP_SKNE_R  = 6'd24;
    localparam logic [5:0] OP_MOV_I   = 6'd25;
    localparam logic [5:0] OP_JMP_V0  = 6'd26;
    localparam logic [5:0] OP_RAND    = 6'd27;
    localparam logic [5:0] OP_DRAW    = 6'd28;
    localparam logic [5:0] OP_SKP     = 6'd29;
    localparam logic [5:0] OP_SKNP    = 6'd30;
    localparam logic [5:0] OP_GDELAY  = 6'd31;
    localparam logic [5:0] OP_WKEY    = 6'd32;
    localparam logic [5:0] OP_SDELAY  = 6'd33;
    localparam logic [5:0] OP_SSOUND  = 6'd34;
    localparam logic [5:0] OP_ADD_I   = 6'd35;
    localparam logic [5:0] OP_FONT    = 6'd36;
    localparam logic [5:0] OP_XFONT   = 6'd37;
    localparam logic [5:0] OP_BCD     = 6'd38;
    localparam logic [5:0] OP_STRA    = 6'd39;
    localparam logic [5:0] OP_LDRA    = 6'd40;
    localparam logic [5:0] OP_LAST    = OP_LDRA;

    // Flow / ALU classes.
    localparam logic [3:0] FC_NONE  = 4'd0;
    localparam logic [3:0] FC_STOP  = 4'd1;
    localparam logic [3:0] FC_JUMP  = 4'd2;
    localparam logic [3:0] FC_CJUMP = 4'd3;
    localparam logic [3:0] FC_CALL  = 4'd4;
    localparam logic [3:0] FC_ADD   = 4'd5;
    localparam logic [3:0] FC_SUB   = 4'd6;
    localparam logic [3:0] FC_AND   = 4'd7;
    localparam logic [3:0] FC_OR    = 4'd8;
    localparam logic [3:0] FC_XOR   = 4'd9;
    localparam logic [3:0] FC_LOAD  = 4'd10;
    localparam logic [3:0] FC_STORE = 4'd11;
    localparam logic [3:0] FC_PRIV  = 4'd12;

    typedef struct packed {
        logic        valid_res;
        logic [5:0]  operation;
        logic [3:0]  flow_class;
        logic [3:0]  reg_x;
        logic        has_reg_x;
        logic [3:0]  reg_y;
        logic        has_reg_y;
        logic [11:0] immediate;
        logic        has_immediate;
        logic [15:0] target;
        logic        has_target;
    } t_dec_res;

endpackage

// ----- rtl/chip8_instruction_decoder_top.sv -----
// ---------------------------------------------------------------------------
// CHIP-8 / SuperChip instruction decoder
// Two-register stream pipeline around a single-pass word decoder.
// ---------------------------------------------------------------------------
// Usage: each transfer on the slave side carries one instruction word in
// i_s_tdata[15:0] and the address it was fetched from in i_s_tdata[31:16].
// Each word produces exactly one transfer on the master side, in order.
// o_m_tuser is the recognised-instruction flag; o_m_tdata carries the
// operation code, flow class, operand fields with their presence flags and
// the branch target. Rejected words give a zero o_m_tdata.
// An accepted word passes through the input register, then through the
// decoder into the result register, which offers it on the master side.
// Throughput is one word per cycle while the receiver takes results, as
// each register may load while the one after it hands its contents on.
// When the receiver stalls, the result register holds its contents and the
// input register fills behind it, after which o_s_tready falls; nothing is
// lost or repeated. The synchronous active-low reset empties both
// registers, so no result is offered after reset until a word arrives.
// ---------------------------------------------------------------------------
module chip8_instruction_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // opcode [15:0], address [31:16]
    input  logic [c8dec_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // operation [5:0], flow_class [9:6], reg_x [13:10], has_reg_x [14],
    // reg_y [18:15], has_reg_y [19], immediate [31:20], has_immediate [32],
    // target [48:33], has_target [49], zero fill [55:50]
    output logic [c8dec_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // valid_res [0]
    output logic                                 o_m_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready
);

    // Input register: holds the word until the decoder's result can be stored.
    logic        r_in_valid;
    logic        n_in_valid;
    logic [15:0] r_opcode;
    logic [15:0] r_address;

    // Result register.
    logic                r_out_valid;
    logic                n_out_valid;
    c8dec_pkg::t_dec_res r_res;
    c8dec_pkg::t_dec_res dec_res;

    logic out_load;
    logic in_load;

    // The result register may load when empty or when its content leaves now.
    assign out_load   = !r_out_valid || i_m_tready;
    // The input register may load when empty or when its word moves on now.
    assign o_s_tready = !r_in_valid || out_load;
    assign in_load    = i_s_tvalid && o_s_tready;

    c8dec_decode u_decode (
        .i_opcode  (r_opcode),
        .i_address (r_address),
        .o_res     (dec_res)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
        end
        if (out_load) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_opcode  <= i_s_tdata[15:0];
            r_address <= i_s_tdata[31:16];
        end
        if (out_load && r_in_valid) begin
            r_res <= dec_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_res.valid_res;
    assign o_m_tdata  = {6'd0,
                         r_res.has_target,
                         r_res.target,
                         r_res.has_immediate,
                         r_res.immediate,
                         r_res.has_reg_y,
                         r_res.reg_y,
                         r_res.has_reg_x,
                         r_res.reg_x,
                         r_res.flow_class,
                         r_res.operation};

endmodule

// ----- rtl/c8dec_decode.sv -----
// ---------------------------------------------------------------------------
// CHIP-8 word decoder
// Combinational decode of one instruction word and its address.
// ---------------------------------------------------------------------------
module c8dec_decode (
    input  logic [15:0]          i_opcode,
    input  logic [15:0]          i_address,
    output c8dec_pkg::t_dec_res  o_res
);

    logic [11:0] nnn;
    logic [7:0]  kk;
    logic [3:0]  n;
    logic [15:0] skip;

    assign nnn  = i_opcode[11:0];
    assign kk   = i_opcode[7:0];
    assign n    = i_opcode[3:0];
    assign skip = i_address + 16'd4;

    always_comb begin
        logic       ok;
        logic [5:0] op;
        logic [3:0] fc;
        logic       use_x;
        logic       use_y;
        logic       use_imm;
        logic [11:0] imm;
        logic       use_tgt;
        logic [15:0] tgt;

        ok      = 1'b1;
        op      = c8dec_pkg::OP_CLS;
        fc      = c8dec_pkg::FC_NONE;
        use_x   = 1'b0;
        use_y   = 1'b0;
        use_imm = 1'b0;
        imm     = '0;
        use_tgt = 1'b0;
        tgt     = '0;

        case (i_opcode[15:12])
            4'h0: begin
                if (i_opcode == 16'h00E0) begin
                    op = c8dec_pkg::OP_CLS;
                end else if (i_opcode == 16'h00EE) begin
                    op = c8dec_pkg::OP_RTS;
                    fc = c8dec_pkg::FC_STOP;
                end else if (i_opcode == 16'h00FB) begin
                    op = c8dec_pkg::OP_SCRIGHT;
                end else if (i_opcode == 16'h00FC) begin
                    op = c8dec_pkg::OP_SCLEFT;
                end else if (i_opcode == 16'h00FE) begin
                    op = c8dec_pkg::OP_LOW;
                end else if (i_opcode == 16'h00FF) begin
                    op = c8dec_pkg::OP_HIGH;
                end else if (i_opcode[11:4] == 8'h0C) begin
                    op      = c8dec_pkg::OP_SCDOWN;
                    use_imm = 1'b1;
                    imm     = {8'd0, n};
                end else begin
                    op      = c8dec_pkg::OP_SYS;
                    fc      = c8dec_pkg::FC_PRIV;
                    use_imm = 1'b1;
                    imm     = nnn;
                end
            end
            4'h1: begin
                op      = c8dec_pkg::OP_JMP;
                fc      = c8dec_pkg::FC_JUMP;
                use_imm = 1'b1;
                imm     = nnn;
                use_tgt = 1'b1;
                tgt     = {4'd0, nnn};
            end
            4'h2: begin
                op      = c8dec_pkg::OP_CALL;
                fc      = c8dec_pkg::FC_CALL;
                use_imm = 1'b1;
                imm     = nnn;
                use_tgt = 1'b1;
                tgt     = {4'd0, nnn};
            end
            4'h3, 4'h4: begin
                op      = (i_opcode[15:12] == 4'h3) ? c8dec_pkg::OP_SKE_K
                                                    : c8dec_pkg::OP_SKNE_K;
                fc      = c8dec_pkg::FC_CJUMP;
                use_x   = 1'b1;
                use_imm = 1'b1;
                imm     = {4'd0, kk};
                use_tgt = 1'b1;
                tgt     = skip;
            end
            4'h5, 4'h9: begin
                ok      = (n == 4'h0);
                op      = (i_opcode[15:12] == 4'h5) ? c8dec_pkg::OP_SKE_R
                                                    : c8dec_pkg::OP_SKNE_R;
                fc      = c8dec_pkg::FC_CJUMP;
                use_x   = 1'b1;
                use_y   = 1'b1;
                use_tgt = 1'b1;
                tgt     = skip;
            end
            4'h6: begin
                op      = c8dec_pkg::OP_MOV_K;
                fc      = c8dec_pkg::FC_LOAD;
                use_x   = 1'b1;
                use_imm = 1'b1;
                imm     = {4'd0, kk};
            end
            4'h7: begin
                op      = c8dec_pkg::OP_ADD_K;
                fc      = c8dec_pkg::FC_ADD;
                use_x   = 1'b1;
                use_imm = 1'b1;
                imm     = {4'd0, kk};
            end
            4'h8: begin
                use_x = 1'b1;
                use_y = 1'b1;
                case (n)
                    4'h0: begin
                        op = c8dec_pkg::OP_MOV_R;
                        fc = c8dec_pkg::FC_LOAD;
                    end
                    4'h1: begin
                        op = c8dec_pkg::OP_OR;
                        fc = c8dec_pkg::FC_OR;
                    end
                    4'h2: begin
                        op = c8dec_pkg::OP_AND;
                        fc = c8dec_pkg::FC_AND;
                    end
                    4'h3: begin
                        op = c8dec_pkg::OP_XOR;
                        fc = c8dec_pkg::FC_XOR;
                    end
                    4'h4: begin
                        op = c8dec_pkg::OP_ADD_R;
                        fc = c8dec_pkg::FC_ADD;
                    end
                    4'h5: begin
                        op = c8dec_pkg::OP_SUB;
                        fc = c8dec_pkg::FC_SUB;
                    end
                    4'h6: begin
                        op    = c8dec_pkg::OP_SHR;
                        use_y = 1'b0;
                    end
                    4'h7: begin
                        op = c8dec_pkg::OP_SUBN;
                        fc = c8dec_pkg::FC_SUB;
                    end
                    4'hE: begin
                        op    = c8dec_pkg::OP_SHL;
                        use_y = 1'b0;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
            end
            4'hA: begin
                op      = c8dec_pkg::OP_MOV_I;
                fc      = c8dec_pkg::FC_LOAD;
                use_imm = 1'b1;
                imm     = nnn;
            end
            4'hB: begin
                // Computed jump: no static target.
                op      = c8dec_pkg::OP_JMP_V0;
                fc      = c8dec_pkg::FC_JUMP;
                use_imm = 1'b1;
                imm     = nnn;
            end
            4'hC: begin
                op      = c8dec_pkg::OP_RAND;
                use_x   = 1'b1;
                use_imm = 1'b1;
                imm     = {4'd0, kk};
            end
            4'hD: begin
                op      = c8dec_pkg::OP_DRAW;
                use_x   = 1'b1;
                use_y   = 1'b1;
                use_imm = 1'b1;
                imm     = {8'd0, n};
            end
            4'hE: begin
                fc      = c8dec_pkg::FC_CJUMP;
                use_x   = 1'b1;
                use_tgt = 1'b1;
                tgt     = skip;
                case (kk)
                    8'h9E:   op = c8dec_pkg::OP_SKP;
                    8'hA1:   op = c8dec_pkg::OP_SKNP;
                    default: ok = 1'b0;
                endcase
            end
            default: begin
                use_x = 1'b1;
                case (kk)
                    8'h07:   op = c8dec_pkg::OP_GDELAY;
                    8'h0A:   op = c8dec_pkg::OP_WKEY;
                    8'h15:   op = c8dec_pkg::OP_SDELAY;
                    8'h18:   op = c8dec_pkg::OP_SSOUND;
                    8'h1E: begin
                        op = c8dec_pkg::OP_ADD_I;
                        fc = c8dec_pkg::FC_ADD;
                    end
                    8'h29:   op = c8dec_pkg::OP_FONT;
                    8'h30:   op = c8dec_pkg::OP_XFONT;
                    8'h33:   op = c8dec_pkg::OP_BCD;
                    8'h55: begin
                        op = c8dec_pkg::OP_STRA;
                        fc = c8dec_pkg::FC_STORE;
                    end
                    8'h65: begin
                        op = c8dec_pkg::OP_LDRA;
                        fc = c8dec_pkg::FC_LOAD;
                    end
                    default: ok = 1'b0;
                endcase
            end
        endcase

        // Absent operands and rejected words read as zero.
        o_res.valid_res     = ok;
        o_res.operation     = ok ? op : 6'd0;
        o_res.flow_class    = ok ? fc : 4'd0;
        o_res.has_reg_x     = ok & use_x;
        o_res.reg_x         = (ok & use_x) ? i_opcode[11:8] : 4'd0;
        o_res.has_reg_y     = ok & use_y;
        o_res.reg_y         = (ok & use_y) ? i_opcode[7:4] : 4'd0;
        o_res.has_immediate = ok & use_imm;
        o_res.immediate     = (ok & use_imm) ? imm : 12'd0;
        o_res.has_target    = ok & use_tgt;
        o_res.target        = (ok & use_tgt) ? tgt : 16'd0;
    end

endmodule

// ----- rtl/c8dec_checker.sv -----
// ---------------------------------------------------------------------------
// CHIP-8 decoder port checker
// Watches the top level's ports and checks result consistency over time.
// ---------------------------------------------------------------------------
`include "chip8_instruction_decoder_top_assert.svh"

module c8dec_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_tvalid,
    input logic                                 o_s_tready,
    input logic [c8dec_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic                                 o_m_tuser,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready
);

    logic                             m_stall;
    logic                             m_reject;
    logic                             m_no_tgt;
    logic                             s_xfer_free;
    logic [c8dec_pkg::OUT_TDATA_W:0]  m_word;

    assign m_stall     = o_m_tvalid && !i_m_tready;
    assign m_reject    = o_m_tvalid && !o_m_tuser;
    assign m_no_tgt    = o_m_tvalid && !o_m_tdata[49];
    assign s_xfer_free = i_s_tvalid && o_s_tready && !o_m_tvalid;
    assign m_word      = {o_m_tuser, o_m_tdata};

    // A stalled result must stay put.
    `C8DEC_ASSERT_NEXT(a_stall_hold, m_stall, $stable(m_word) && o_m_tvalid, "stalled result changed")

    // A rejected word reports nothing at all.
    `C8DEC_ASSERT_NOW(a_invalid_zero, m_reject, o_m_tdata == '0, "rejected word has fields set")

    // The operation code stays within the defined set.
    `C8DEC_ASSERT_NOW(a_op_range, o_m_tvalid, o_m_tdata[5:0] <= c8dec_pkg::OP_LAST, "bad op code")

    // An absent target reads as zero.
    `C8DEC_ASSERT_NOW(a_target_zero, m_no_tgt, o_m_tdata[48:33] == 16'd0, "target without flag")

    // An accepted word when the output side is free gives a result once it has passed the input and result registers.
    `C8DEC_ASSERT_NEXT(a_latency, s_xfer_free, ##1 o_m_tvalid, "result late after transfer")

endmodule

bind chip8_instruction_decoder_top c8dec_checker u_c8dec_checker (.*);
